/* rtl/core/iee_pkg.sv */
// shared types, constants and helper functions of the infix expression evaluator
`timescale 1ns / 1ps
package iee_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int VAL_W           = 48;
    localparam int CHAR_W          = 8;
    localparam int POW_W           = 30;

    localparam logic [VAL_W-1:0] VMAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] VMIN_MAG = 48'h8000_0000_0000;

    // operator codes as kept on the operator stack
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_LPAR = 3'd4;
    localparam logic [2:0] OP_RPAR = 3'd5;
    localparam logic [2:0] OP_END  = 3'd6;

    // precedence table actions
    localparam logic [1:0] PREC_ERR    = 2'd0;
    localparam logic [1:0] PREC_PUSH   = 2'd1;
    localparam logic [1:0] PREC_REDUCE = 2'd2;
    localparam logic [1:0] PREC_MATCH  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_SYNTAX = 2'd1;
    localparam logic [1:0] STAT_OVFL   = 2'd2;
    localparam logic [1:0] STAT_DIV0   = 2'd3;

    // character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic       load_char;
        logic       digit_upd;
        logic       point_upd;
        logic       num_clear;
        logic       expr_clear;
        logic       div_start;
        logic       div_conv;
        logic       mul_start;
        logic       addsub;
        logic       res_zero;
        logic       op_rd;
        logic       op_push;
        logic       op_pop;
        logic       num_rd_b;
        logic       num_rd_a;
        logic       num_rd_top;
        logic       latch_b;
        logic       latch_a;
        logic       num_push;
        logic       set_err;
        logic [1:0] err_code;
        logic       use_end;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic       is_digit;
        logic       is_point;
        logic       is_end;
        logic       in_number;
        logic       err_set;
        logic [1:0] prec;
        logic [2:0] top_op;
        logic       op_full;
        logic       num_full;
        logic       b_zero;
        logic       unit_done;
    } sts_t;

    // any character that is not an operator acts as '+'
    function automatic logic [2:0] op_index(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            CH_MINUS: r = OP_SUB;
            CH_STAR:  r = OP_MUL;
            CH_SLASH: r = OP_DIV;
            CH_LPAR:  r = OP_LPAR;
            CH_RPAR:  r = OP_RPAR;
            default:  r = OP_ADD;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] prec_lookup(input logic [2:0] top, input logic [2:0] n);
        logic [13:0] row;
        unique case (top)
            OP_ADD, OP_SUB: row = {PREC_REDUCE, PREC_REDUCE, PREC_PUSH, PREC_PUSH,
                                   PREC_PUSH, PREC_REDUCE, PREC_REDUCE};
            OP_MUL, OP_DIV: row = {PREC_REDUCE, PREC_REDUCE, PREC_REDUCE, PREC_REDUCE,
                                   PREC_PUSH, PREC_REDUCE, PREC_REDUCE};
            OP_LPAR:        row = {PREC_PUSH, PREC_PUSH, PREC_PUSH, PREC_PUSH,
                                   PREC_PUSH, PREC_MATCH, PREC_ERR};
            OP_RPAR:        row = {PREC_REDUCE, PREC_REDUCE, PREC_REDUCE, PREC_REDUCE,
                                   PREC_ERR, PREC_REDUCE, PREC_REDUCE};
            default:        row = {PREC_PUSH, PREC_PUSH, PREC_PUSH, PREC_PUSH,
                                   PREC_PUSH, PREC_ERR, PREC_MATCH};
        endcase
        // column 0 sits in the top bits
        case (n)
            3'd0:    return row[13:12];
            3'd1:    return row[11:10];
            3'd2:    return row[9:8];
            3'd3:    return row[7:6];
            3'd4:    return row[5:4];
            3'd5:    return row[3:2];
            default: return row[1:0];
        endcase
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [3:0] k);
        logic [POW_W-1:0] p;
        case (k)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

    function automatic logic [VAL_W-1:0] abs_val(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [VAL_W-1:0] apply_sign(input logic [VAL_W-1:0] mag,
                                                    input logic neg);
        return neg ? (~mag + 1'b1) : mag;
    endfunction

endpackage

/* rtl/core/iee_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module iee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/core/iee_dp.sv */
// datapath: number parsing, stacks, shared divider and multiplier, result register
`timescale 1ns / 1ps
module iee_dp #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [iee_pkg::CHAR_W-1:0]  char_in,
    input  logic                        end_in,
    input  iee_pkg::cmd_t               cmd,
    output iee_pkg::sts_t               sts,
    output logic [iee_pkg::VAL_W-1:0]   out_value,
    output logic [1:0]                  out_status
);
    import iee_pkg::*;

    localparam int AW        = $clog2(STACK_DEPTH);
    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int DIV_STEPS = VAL_W + FRAC_BITS;
    localparam int DCW       = $clog2(DIV_STEPS);
    localparam int PW        = 2 * VAL_W;
    localparam int HW        = VAL_W / 2;

    logic [7:0]       char_reg;
    logic             end_reg;
    logic [VAL_W-1:0] accum_reg;
    logic [3:0]       fdig_reg;
    logic             in_num_reg, point_reg, frozen_reg;
    logic [1:0]       err_reg;
    logic [CW-1:0]    op_cnt_reg, num_cnt_reg;
    logic [2:0]       top_reg;
    logic             had_reg;
    logic [VAL_W-1:0] a_reg, b_reg, res_reg;
    logic             done_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic [1:0]       out_status_reg;

    // divider
    logic             div_busy_reg, div_fin_reg, qovf_reg, neg_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic [VAL_W-1:0] dvd_reg, dvs_reg, quo_reg, lim_reg;
    logic [VAL_W:0]   rem_reg;

    // multiplier
    logic             mul_busy_reg, mul_fin_reg;
    logic [2:0]       mcnt_reg;
    logic [1:0]       psel_reg;
    logic [VAL_W-1:0] ma_reg, mb_reg, pp_reg;
    logic [PW-1:0]    acc_reg;

    logic [2:0]       op_q;
    logic [VAL_W-1:0] num_q;
    logic [2:0]       n_code, top_now;
    logic [51:0]      t10, t9;
    logic [VAL_W:0]   rem_sh, rem_sub;
    logic             rem_ge;
    logic [VAL_W:0]   sum_w;
    logic [VAL_W-1:0] mag_a, mag_b, div_mag, mul_mag;
    logic [PW-1:0]    prod_sh;
    logic [HW-1:0]    ha, hb;
    logic [PW-1:0]    pp_shift;
    logic             neg_ab;

    assign n_code  = cmd.use_end ? OP_END : op_index(char_reg);
    assign top_now = (op_cnt_reg >= CW'(2)) ? ((op_q > OP_END) ? OP_END : op_q) : OP_END;
    assign t10     = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
                   + {48'd0, char_reg[3:0]};
    assign t9      = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1) + 52'd9;
    assign mag_a   = abs_val(a_reg);
    assign mag_b   = abs_val(b_reg);
    assign neg_ab  = a_reg[VAL_W-1] ^ b_reg[VAL_W-1];

    assign rem_sh  = {rem_reg[VAL_W-1:0], dvd_reg[VAL_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign div_mag = (qovf_reg || quo_reg > lim_reg) ? lim_reg : quo_reg;

    assign prod_sh = acc_reg >> FRAC_BITS;
    assign mul_mag = ((|prod_sh[PW-1:VAL_W]) || prod_sh[VAL_W-1:0] > lim_reg)
                   ? lim_reg : prod_sh[VAL_W-1:0];
    assign ha      = mcnt_reg[1] ? ma_reg[VAL_W-1:HW] : ma_reg[HW-1:0];
    assign hb      = mcnt_reg[0] ? mb_reg[VAL_W-1:HW] : mb_reg[HW-1:0];
    assign pp_shift = (psel_reg == 2'd3) ? ({{VAL_W{1'b0}}, pp_reg} << VAL_W)
                    : (psel_reg == 2'd0) ? {{VAL_W{1'b0}}, pp_reg}
                    : ({{VAL_W{1'b0}}, pp_reg} << HW);

    assign sum_w = (top_reg == OP_SUB)
                 ? {a_reg[VAL_W-1], a_reg} - {b_reg[VAL_W-1], b_reg}
                 : {a_reg[VAL_W-1], a_reg} + {b_reg[VAL_W-1], b_reg};

    iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_op_ram (
        .aclk  (aclk),
        .we    (cmd.op_push),
        .waddr (op_cnt_reg[AW-1:0]),
        .wdata (n_code),
        .re    (cmd.op_rd),
        .raddr (AW'(op_cnt_reg - CW'(1))),
        .rdata (op_q)
    );

    iee_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_num_ram (
        .aclk  (aclk),
        .we    (cmd.num_push),
        .waddr (num_cnt_reg[AW-1:0]),
        .wdata (res_reg),
        .re    ((cmd.num_rd_a || cmd.num_rd_b || cmd.num_rd_top) && num_cnt_reg != '0),
        .raddr (AW'(num_cnt_reg - CW'(1))),
        .rdata (num_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_char) begin
            char_reg <= char_in;
            end_reg  <= end_in;
        end
        if (cmd.op_pop) begin
            top_reg <= top_now;
        end
        if (cmd.num_rd_a || cmd.num_rd_b || cmd.num_rd_top) begin
            had_reg <= (num_cnt_reg != '0);
        end
        if (cmd.latch_b) begin
            b_reg <= had_reg ? num_q : '0;
        end
        if (cmd.latch_a) begin
            a_reg <= had_reg ? num_q : '0;
        end
        if (cmd.out_load) begin
            out_value_reg  <= (err_reg == STAT_OK && had_reg) ? num_q : '0;
            out_status_reg <= err_reg;
        end
        if (cmd.addsub) begin
            if (sum_w[VAL_W] != sum_w[VAL_W-1]) begin
                res_reg <= sum_w[VAL_W] ? VMIN_MAG : VMAX;
            end else begin
                res_reg <= sum_w[VAL_W-1:0];
            end
        end else if (cmd.res_zero) begin
            res_reg <= '0;
        end else if (div_fin_reg) begin
            res_reg <= apply_sign(div_mag, neg_reg);
        end else if (mul_fin_reg) begin
            res_reg <= apply_sign(mul_mag, neg_reg);
        end
        // operand loads and iteration steps of the divider and multiplier
        if (cmd.div_start) begin
            if (cmd.div_conv) begin
                dvd_reg <= accum_reg;
                dvs_reg <= {{(VAL_W-POW_W){1'b0}}, pow10(fdig_reg)};
                lim_reg <= VMAX;
                neg_reg <= 1'b0;
            end else begin
                dvd_reg <= mag_a;
                dvs_reg <= mag_b;
                lim_reg <= neg_ab ? VMIN_MAG : VMAX;
                neg_reg <= neg_ab;
            end
            rem_reg  <= '0;
            quo_reg  <= '0;
            qovf_reg <= 1'b0;
            dcnt_reg <= '0;
        end else if (div_busy_reg) begin
            dvd_reg  <= {dvd_reg[VAL_W-2:0], 1'b0};
            rem_reg  <= rem_ge ? rem_sub : rem_sh;
            quo_reg  <= {quo_reg[VAL_W-2:0], rem_ge};
            qovf_reg <= qovf_reg | quo_reg[VAL_W-1];
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.mul_start) begin
            ma_reg   <= mag_a;
            mb_reg   <= mag_b;
            lim_reg  <= neg_ab ? VMIN_MAG : VMAX;
            neg_reg  <= neg_ab;
            acc_reg  <= '0;
            mcnt_reg <= '0;
        end else if (mul_busy_reg) begin
            if (mcnt_reg != 3'd4) begin
                pp_reg   <= VAL_W'(ha * hb);
                psel_reg <= mcnt_reg[1:0];
            end
            if (mcnt_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_shift;
            end
            mcnt_reg <= mcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg    <= '0;
            fdig_reg     <= '0;
            in_num_reg   <= 1'b0;
            point_reg    <= 1'b0;
            frozen_reg   <= 1'b0;
            err_reg      <= STAT_OK;
            op_cnt_reg   <= CW'(1);
            num_cnt_reg  <= '0;
            div_busy_reg <= 1'b0;
            div_fin_reg  <= 1'b0;
            mul_busy_reg <= 1'b0;
            mul_fin_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            div_fin_reg <= div_busy_reg && dcnt_reg == DCW'(DIV_STEPS - 1);
            mul_fin_reg <= mul_busy_reg && mcnt_reg == 3'd4;
            done_reg    <= div_fin_reg || mul_fin_reg;
            if (cmd.div_start) begin
                div_busy_reg <= 1'b1;
            end else if (dcnt_reg == DCW'(DIV_STEPS - 1)) begin
                div_busy_reg <= 1'b0;
            end
            if (cmd.mul_start) begin
                mul_busy_reg <= 1'b1;
            end else if (mcnt_reg == 3'd4) begin
                mul_busy_reg <= 1'b0;
            end

            if (cmd.digit_upd) begin
                in_num_reg <= 1'b1;
                if (!frozen_reg) begin
                    if (!point_reg) begin
                        accum_reg <= (t10 > {4'd0, VMAX}) ? VMAX : t10[VAL_W-1:0];
                    end else if (fdig_reg < 4'd9 && t9 <= {4'd0, VMAX}) begin
                        accum_reg <= t10[VAL_W-1:0];
                        fdig_reg  <= fdig_reg + 1'b1;
                    end
                end
            end
            if (cmd.point_upd) begin
                if (point_reg) begin
                    frozen_reg <= 1'b1;
                end else begin
                    point_reg <= 1'b1;
                end
            end
            if (cmd.num_clear || cmd.expr_clear) begin
                accum_reg  <= '0;
                fdig_reg   <= '0;
                in_num_reg <= 1'b0;
                point_reg  <= 1'b0;
                frozen_reg <= 1'b0;
            end

            if (cmd.op_push) begin
                op_cnt_reg <= op_cnt_reg + 1'b1;
            end else if (cmd.op_pop && op_cnt_reg != '0) begin
                op_cnt_reg <= op_cnt_reg - 1'b1;
            end
            if (cmd.num_push) begin
                num_cnt_reg <= num_cnt_reg + 1'b1;
            end else if ((cmd.num_rd_a || cmd.num_rd_b) && num_cnt_reg != '0) begin
                num_cnt_reg <= num_cnt_reg - 1'b1;
            end
            if (cmd.set_err && err_reg == STAT_OK) begin
                err_reg <= cmd.err_code;
            end
            if (cmd.expr_clear) begin
                op_cnt_reg  <= CW'(1);
                num_cnt_reg <= '0;
                err_reg     <= STAT_OK;
            end
        end
    end

    always_comb begin
        sts.is_digit  = char_reg >= CH_ZERO && char_reg <= CH_NINE;
        sts.is_point  = char_reg == CH_POINT;
        sts.is_end    = end_reg;
        sts.in_number = in_num_reg;
        sts.err_set   = err_reg != STAT_OK;
        sts.prec      = prec_lookup(top_now, n_code);
        sts.top_op    = top_reg;
        sts.op_full   = op_cnt_reg >= CW'(STACK_DEPTH);
        sts.num_full  = num_cnt_reg >= CW'(STACK_DEPTH);
        sts.b_zero    = b_reg == '0;
        sts.unit_done = done_reg;
    end

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        op_cnt_reg <= CW'(STACK_DEPTH) && num_cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_units_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_busy_reg && mul_busy_reg))
        else $error("divider and multiplier busy together");
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != STAT_OK && !cmd.expr_clear) |=> err_reg == $past(err_reg))
        else $error("first error code overwritten");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.expr_clear |=> (op_cnt_reg == CW'(1) && num_cnt_reg == '0 && !in_num_reg))
        else $error("expression state not cleared");
endmodule

/* rtl/core/iee_ctrl.sv */
// controller: sequences parsing, reductions and result delivery
`timescale 1ns / 1ps
module iee_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  iee_pkg::sts_t sts,
    output iee_pkg::cmd_t cmd
);
    import iee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FIN, S_FIN_WAIT, S_FIN_PUSH, S_FEED_RD, S_FEED_DEC,
        S_POP_A, S_APPLY, S_EXEC, S_UNIT_WAIT, S_PUSH, S_ENDCHK, S_RES_RD, S_RES_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   m_tvalid_reg;
    state_t ret_state;

    assign ret_state = phase_reg ? S_RES_RD : S_ENDCHK;
    assign s_tready  = state_reg == S_IDLE;
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        cmd         = '0;
        cmd.use_end = phase_reg;
        state_next  = state_reg;
        phase_next  = phase_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_char = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.err_set) begin
                    state_next = S_ENDCHK;
                end else if (sts.is_digit) begin
                    cmd.digit_upd = 1'b1;
                    state_next    = S_ENDCHK;
                end else if (sts.is_point && sts.in_number) begin
                    cmd.point_upd = 1'b1;
                    state_next    = S_ENDCHK;
                end else begin
                    phase_next = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (sts.in_number) begin
                    cmd.div_start = 1'b1;
                    cmd.div_conv  = 1'b1;
                    state_next    = S_FIN_WAIT;
                end else begin
                    state_next = S_FEED_RD;
                end
            end
            S_FIN_WAIT: begin
                if (sts.unit_done) begin
                    state_next = S_FIN_PUSH;
                end
            end
            S_FIN_PUSH: begin
                cmd.num_clear = 1'b1;
                if (sts.num_full) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = STAT_OVFL;
                end else begin
                    cmd.num_push = 1'b1;
                end
                state_next = S_FEED_RD;
            end
            S_FEED_RD: begin
                if (sts.err_set) begin
                    state_next = ret_state;
                end else begin
                    cmd.op_rd  = 1'b1;
                    state_next = S_FEED_DEC;
                end
            end
            S_FEED_DEC: begin
                unique case (sts.prec)
                    PREC_PUSH: begin
                        if (sts.op_full) begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = STAT_OVFL;
                        end else begin
                            cmd.op_push = 1'b1;
                        end
                        state_next = ret_state;
                    end
                    PREC_MATCH: begin
                        cmd.op_pop = 1'b1;
                        state_next = ret_state;
                    end
                    PREC_REDUCE: begin
                        cmd.op_pop   = 1'b1;
                        cmd.num_rd_b = 1'b1;
                        state_next   = S_POP_A;
                    end
                    default: begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = STAT_SYNTAX;
                        state_next   = ret_state;
                    end
                endcase
            end
            S_POP_A: begin
                cmd.latch_b  = 1'b1;
                cmd.num_rd_a = 1'b1;
                state_next   = S_APPLY;
            end
            S_APPLY: begin
                cmd.latch_a = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC: begin
                case (sts.top_op)
                    OP_ADD, OP_SUB: begin
                        cmd.addsub = 1'b1;
                        state_next = S_PUSH;
                    end
                    OP_MUL: begin
                        cmd.mul_start = 1'b1;
                        state_next    = S_UNIT_WAIT;
                    end
                    OP_DIV: begin
                        if (sts.b_zero) begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = STAT_DIV0;
                            state_next   = ret_state;
                        end else begin
                            cmd.div_start = 1'b1;
                            state_next    = S_UNIT_WAIT;
                        end
                    end
                    default: begin
                        cmd.res_zero = 1'b1;
                        state_next   = S_PUSH;
                    end
                endcase
            end
            S_UNIT_WAIT: begin
                if (sts.unit_done) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (sts.num_full) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = STAT_OVFL;
                end else begin
                    cmd.num_push = 1'b1;
                end
                state_next = S_FEED_RD;
            end
            S_ENDCHK: begin
                if (!sts.is_end) begin
                    state_next = S_IDLE;
                end else begin
                    phase_next = 1'b1;
                    state_next = sts.err_set ? S_RES_RD : S_FIN;
                end
            end
            S_RES_RD: begin
                cmd.num_rd_top = 1'b1;
                state_next     = S_RES_OUT;
            end
            S_RES_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    cmd.expr_clear = 1'b1;
                    phase_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RES_OUT && m_tvalid_reg && !m_tready) |=> state_reg == S_RES_OUT)
        else $error("result overwritten while pending");
    a_phase_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RES_RD) |-> phase_reg)
        else $error("result read outside end processing");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_char |=> state_reg == S_DISPATCH)
        else $error("accepted transaction not dispatched");
endmodule

/* rtl/core/infix_expression_evaluator.sv */
// top level of the infix expression evaluator
`timescale 1ns / 1ps
// Evaluates an arithmetic expression over + - * / ( ) and decimal numbers fed one
// character per input transaction (s_tdata = character, s_tlast = last character).
// Numbers become signed fixed point with FRAC_BITS fraction bits; any other
// character acts as '+', a leading minus negates, and every arithmetic result
// saturates to 48 bits. On the last character one output transaction carries the
// value and a status (0 ok, 1 syntax, 2 stack overflow, 3 divide by zero; value is
// 0 on error). Items are handled one at a time; an operator first converts the pending
// number through the shared bit-serial divider, then each reduction applies + and -
// directly, * through the multiplier and / through the divider.
// A finished result waits in the output register while new input is accepted.
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_expr
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [47:0] value, [49:48] status, rest zero
);
    import iee_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic [VAL_W-1:0] out_value;
    logic [1:0]       out_status;

    // sequencing of parse, reduce and output steps
    iee_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stacks, number accumulator and arithmetic units
    iee_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_in    (s_tdata),
        .end_in     (s_tlast),
        .cmd        (cmd),
        .sts        (sts),
        .out_value  (out_value),
        .out_status (out_status)
    );

    // pack result transaction, upper bits padded with zeros
    assign m_tdata = {6'd0, out_status, out_value};
endmodule
